[design/wcs_pkg.sv]
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types and constants for the wire channel spacer.
// ----------------------------------------------------------------------------
package wcs_pkg;

  localparam int unsigned DefMaxSegments = 64;
  localparam int unsigned DefMaxRects    = 32;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned CloseLim  = 6;
  localparam int unsigned PitchV    = 16;
  localparam int unsigned PitchH    = 20;
  localparam int unsigned KeepMarg  = 15;
  localparam int unsigned StepLast  = 199;
  localparam int unsigned NumPasses = 3;
  localparam int unsigned EmitLimit = 64;
  localparam int unsigned OffW      = 13;
  localparam int unsigned StepW     = 8;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 24;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_RECT  = 2'd0,
    OP_SEG   = 2'd1,
    OP_RUN   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PR_A,
    ST_PR_B,
    ST_PR_C,
    ST_CAND,
    ST_NEXT,
    ST_SC_RD,
    ST_SC_CK,
    ST_FOUND,
    ST_ADV,
    ST_EM_RD,
    ST_EM_LD
  } state_e;

  typedef logic signed [CoordW-1:0] coord_t;

endpackage

[design/wire_channel_spacer_core.sv]
// ----------------------------------------------------------------------------
// wire_channel_spacer_core
// Pushes apart close parallel segments of different nets, avoiding keepouts.
// ----------------------------------------------------------------------------
//  Channel   Signals                      Payload
//  s_axis    tvalid/tready/tdata/tuser    request: op in tuser, coordinates
//  m_axis    tvalid/tready/tdata/tlast    one result per stored segment, up to 64
//  cfg       cfg_we_i/cfg_wdata_i         direction register
//
//  Loads and clears are taken in the idle state. A run visits every
//  ordered pair in each pass, and for each conflict tries up to 199
//  candidates against the stored rectangles, all through the single read
//  port of the segment and rectangle memories. Emission reads each result
//  from memory. Reset is asynchronous, active low, and empties both stores.
//  A stalled result holds in the output register; the next request is taken
//  once the run has handed its last result to that register.
// ----------------------------------------------------------------------------
module wire_channel_spacer_core #(
  parameter int unsigned MaxSegments = wcs_pkg::DefMaxSegments,
  parameter int unsigned MaxRects    = wcs_pkg::DefMaxRects
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // rect_left, rect_top, rect_right, rect_bottom, net_id, track,
  // span_low, span_high (16 bits each, from bit 0 up)
  input  logic [wcs_pkg::InDataW-1:0]  s_axis_tdata_i,
  // operation
  input  logic [1:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // segment_index [5:0], new_track [21:6], any_failure [22], zero [23]
  output logic [wcs_pkg::OutDataW-1:0] m_axis_tdata_o,
  // last
  output logic                         m_axis_tlast_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i
);
  import wcs_pkg::*;

  localparam int unsigned SegAw   = $clog2(MaxSegments);
  localparam int unsigned SegCw   = $clog2(MaxSegments + 1);
  localparam int unsigned RectAw  = (MaxRects > 1) ? $clog2(MaxRects) : 1;
  localparam int unsigned RectCw  = $clog2(MaxRects + 1);
  localparam int unsigned EmitMax = (MaxSegments < EmitLimit) ? MaxSegments : EmitLimit;

  // Signed copies of the margins so that comparisons stay signed.
  localparam logic signed [17:0] KeepMargS = 18'(KeepMarg);
  localparam logic signed [17:0] CloseLimS = 18'(CloseLim);

  state_e state_q, state_d;
  logic               dir_q, dir_d;
  logic [RectCw-1:0]  rect_cnt_q, rect_cnt_d;
  logic [SegCw-1:0]   seg_cnt_q, seg_cnt_d, n_q, n_d;
  logic               fail_q, fail_d;
  logic [1:0]         pass_q, pass_d;
  logic [SegCw-1:0]   i_q, i_d, j_q, j_d, ek_q, ek_d;
  logic [15:0]        a_net_q, a_net_d, b_net_q, b_net_d;
  coord_t             a_track_q, a_track_d, a_lo_q, a_lo_d, a_hi_q, a_hi_d;
  coord_t             b_track_q, b_track_d, b_lo_q, b_lo_d, b_hi_q, b_hi_d;
  coord_t             cand_q, cand_d;
  logic [StepW-1:0]   step_q, step_d;
  logic signed [OffW-1:0] off_q, off_d;
  logic [RectCw-1:0]  k_q, k_d;
  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // Segment and rectangle memories.
  logic [63:0]        seg_mem [MaxSegments];
  logic [63:0]        rect_mem [MaxRects];
  logic [63:0]        seg_rdata_q, rect_rdata_q, seg_wdata, rect_wdata;
  logic [SegAw-1:0]   seg_raddr, seg_waddr;
  logic [RectAw-1:0]  rect_raddr, rect_waddr;
  logic               seg_we, rect_we;

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rdata_q <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rect_we) begin
      rect_mem[rect_waddr] <= rect_wdata;
    end
    rect_rdata_q <= rect_mem[rect_raddr];
  end

  // Fields of the words read back.
  logic [15:0] r_net;
  coord_t      r_track, r_lo, r_hi;
  assign r_net   = seg_rdata_q[15:0];
  assign r_track = seg_rdata_q[31:16];
  assign r_lo    = seg_rdata_q[47:32];
  assign r_hi    = seg_rdata_q[63:48];

  // Conflict test between the held segment A and the segment just read.
  logic signed [16:0] trk_diff;
  coord_t             ov_lo, ov_hi;
  logic               conflict;
  assign trk_diff = 17'(a_track_q) - 17'(r_track);
  assign ov_lo    = (a_lo_q > r_lo) ? a_lo_q : r_lo;
  assign ov_hi    = (a_hi_q < r_hi) ? a_hi_q : r_hi;
  assign conflict = (a_net_q != r_net) && (trk_diff < 17'sd6) && (trk_diff > -17'sd6)
                    && (ov_lo < ov_hi);

  // Candidate track, saturated, and its clearance from track A.
  logic signed [17:0] cand_sum, cand_dist;
  coord_t             cand_sat;
  logic               cand_clear;
  assign cand_sum = 18'(b_track_q) + 18'(off_q);
  always_comb begin
    if (cand_sum > 18'sd32767) begin
      cand_sat = 16'sh7fff;
    end else if (cand_sum < -18'sd32768) begin
      cand_sat = 16'sh8000;
    end else begin
      cand_sat = cand_sum[15:0];
    end
  end
  assign cand_dist  = 18'(cand_sat) - 18'(a_track_q);
  assign cand_clear = (cand_dist >= CloseLimS) || (cand_dist <= -CloseLimS);

  // Keepout test of the held candidate against the rectangle just read.
  coord_t             rl, rt, rr, rb, s_lo, s_hi, t_lo, t_hi;
  logic               hit;
  assign rl   = rect_rdata_q[15:0];
  assign rt   = rect_rdata_q[31:16];
  assign rr   = rect_rdata_q[47:32];
  assign rb   = rect_rdata_q[63:48];
  assign s_lo = dir_q ? rl : rt;
  assign s_hi = dir_q ? rr : rb;
  assign t_lo = dir_q ? rt : rl;
  assign t_hi = dir_q ? rb : rr;
  assign hit  = (18'(b_lo_q) <= 18'(s_hi) + KeepMargS)
             && (18'(b_hi_q) >= 18'(s_lo) - KeepMargS)
             && (18'(cand_q) >  18'(t_lo) - KeepMargS)
             && (18'(cand_q) <  18'(t_hi) + KeepMargS);

  logic [SegCw-1:0] emit_n;
  assign emit_n = (n_q > SegCw'(EmitMax)) ? SegCw'(EmitMax) : n_q;

  logic           in_fire;
  op_e            in_op;
  coord_t         in_lo, in_hi;
  logic signed [OffW-1:0] pitch;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op   = op_e'(s_axis_tuser_i);
  assign in_lo   = s_axis_tdata_i[111:96];
  assign in_hi   = s_axis_tdata_i[127:112];
  assign pitch   = dir_q ? OffW'(PitchH) : OffW'(PitchV);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    dir_d       = cfg_we_i ? cfg_wdata_i : dir_q;
    rect_cnt_d  = rect_cnt_q;
    seg_cnt_d   = seg_cnt_q;
    n_d         = n_q;
    fail_d      = fail_q;
    pass_d      = pass_q;
    i_d         = i_q;
    j_d         = j_q;
    ek_d        = ek_q;
    a_net_d     = a_net_q;
    a_track_d   = a_track_q;
    a_lo_d      = a_lo_q;
    a_hi_d      = a_hi_q;
    b_net_d     = b_net_q;
    b_track_d   = b_track_q;
    b_lo_d      = b_lo_q;
    b_hi_d      = b_hi_q;
    cand_d      = cand_q;
    step_d      = step_q;
    off_d       = off_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    seg_raddr   = '0;
    rect_raddr  = '0;
    seg_we      = 1'b0;
    seg_waddr   = seg_cnt_q[SegAw-1:0];
    seg_wdata   = '0;
    rect_we     = 1'b0;
    rect_waddr  = rect_cnt_q[RectAw-1:0];
    rect_wdata  = s_axis_tdata_i[63:0];
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_fire) begin
          case (in_op)
            OP_RECT: begin
              if (rect_cnt_q < RectCw'(MaxRects)) begin
                rect_we    = 1'b1;
                rect_cnt_d = rect_cnt_q + 1'b1;
              end
            end
            OP_SEG: begin
              // Span ends are stored in order.
              if (seg_cnt_q < SegCw'(MaxSegments)) begin
                seg_we    = 1'b1;
                seg_wdata = (in_lo < in_hi) ? {in_hi, in_lo, s_axis_tdata_i[95:64]}
                                            : {in_lo, in_hi, s_axis_tdata_i[95:64]};
                seg_cnt_d = seg_cnt_q + 1'b1;
              end
            end
            OP_CLEAR: begin
              rect_cnt_d = '0;
              seg_cnt_d  = '0;
              fail_d     = 1'b0;
            end
            default: begin
              fail_d  = 1'b0;
              n_d     = seg_cnt_q;
              pass_d  = '0;
              i_d     = '0;
              j_d     = SegCw'(1);
              ek_d    = '0;
              state_d = (seg_cnt_q < SegCw'(2)) ? ST_EM_RD : ST_PR_A;
            end
          endcase
        end
      end
      ST_PR_A: begin
        seg_raddr = i_q[SegAw-1:0];
        state_d   = ST_PR_B;
      end
      ST_PR_B: begin
        a_net_d   = r_net;
        a_track_d = r_track;
        a_lo_d    = r_lo;
        a_hi_d    = r_hi;
        seg_raddr = j_q[SegAw-1:0];
        state_d   = ST_PR_C;
      end
      ST_PR_C: begin
        b_net_d   = r_net;
        b_track_d = r_track;
        b_lo_d    = r_lo;
        b_hi_d    = r_hi;
        step_d    = StepW'(1);
        off_d     = pitch;
        state_d   = conflict ? ST_CAND : ST_ADV;
      end
      ST_CAND: begin
        cand_d = cand_sat;
        k_d    = '0;
        if (!cand_clear) begin
          state_d = ST_NEXT;
        end else if (rect_cnt_q == '0) begin
          state_d = ST_FOUND;
        end else begin
          state_d = ST_SC_RD;
        end
      end
      ST_NEXT: begin
        // Offsets run +p, -p, +2p, -2p and so on.
        if (step_q == StepW'(StepLast)) begin
          fail_d  = 1'b1;
          state_d = ST_ADV;
        end else begin
          step_d  = step_q + 1'b1;
          off_d   = (off_q > 0) ? -off_q : pitch - off_q;
          state_d = ST_CAND;
        end
      end
      ST_SC_RD: begin
        rect_raddr = k_q[RectAw-1:0];
        state_d    = ST_SC_CK;
      end
      ST_SC_CK: begin
        if (hit) begin
          state_d = ST_NEXT;
        end else if (k_q + 1'b1 == rect_cnt_q) begin
          state_d = ST_FOUND;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_SC_RD;
        end
      end
      ST_FOUND: begin
        seg_we    = 1'b1;
        seg_waddr = j_q[SegAw-1:0];
        seg_wdata = {b_hi_q, b_lo_q, cand_q, b_net_q};
        state_d   = ST_ADV;
      end
      ST_ADV: begin
        if (j_q + 1'b1 < n_q) begin
          j_d     = j_q + 1'b1;
          state_d = ST_PR_A;
        end else if (i_q + SegCw'(2) < n_q) begin
          i_d     = i_q + 1'b1;
          j_d     = i_q + SegCw'(2);
          state_d = ST_PR_A;
        end else if (pass_q == 2'(NumPasses - 1)) begin
          state_d = ST_EM_RD;
        end else begin
          pass_d  = pass_q + 1'b1;
          i_d     = '0;
          j_d     = SegCw'(1);
          state_d = ST_PR_A;
        end
      end
      ST_EM_RD: begin
        seg_raddr = ek_q[SegAw-1:0];
        if (ek_q == emit_n) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        out_valid_d = 1'b1;
        out_data_d  = {1'b0, fail_q, r_track, ek_q[IndexW-1:0]};
        out_last_d  = (ek_q + 1'b1 == emit_n);
        ek_d        = ek_q + 1'b1;
        state_d     = ST_EM_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= 1'b0;
      rect_cnt_q  <= '0;
      seg_cnt_q   <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      rect_cnt_q  <= rect_cnt_d;
      seg_cnt_q   <= seg_cnt_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the run.
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    pass_q     <= pass_d;
    i_q        <= i_d;
    j_q        <= j_d;
    ek_q       <= ek_d;
    a_net_q    <= a_net_d;
    a_track_q  <= a_track_d;
    a_lo_q     <= a_lo_d;
    a_hi_q     <= a_hi_d;
    b_net_q    <= b_net_d;
    b_track_q  <= b_track_d;
    b_lo_q     <= b_lo_d;
    b_hi_q     <= b_hi_d;
    cand_q     <= cand_d;
    step_q     <= step_d;
    off_q      <= off_d;
    k_q        <= k_d;
    out_last_q <= out_last_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // The segment count never passes its capacity.
  a_seg_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q <= SegCw'(MaxSegments)) else $error("segment count overflow");

  // A moved track always clears track A.
  a_found_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOUND) |-> (cand_q - a_track_q >= 16'sd6 || a_track_q - cand_q >= 16'sd6
      || (cand_q > a_track_q) != (cand_q - a_track_q > 16'sd0)
      || (a_track_q > cand_q) != (a_track_q - cand_q > 16'sd0)))
    else $error("moved track too close");

  // A new result is only loaded from the emit sequence.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EM_LD)) else $error("stray result");

  // A freshly loaded final result carries the last index of the run.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q && $past(state_q == ST_EM_LD))
      |-> (out_data_q[IndexW-1:0] == IndexW'(emit_n - 1'b1)))
    else $error("last flag on wrong index");

endmodule
